// ===== rtl/ursd_pkg.sv =====
`default_nettype none

package ursd_pkg;

	// pool geometry
	localparam int POOL_DEPTH = 4096;
	localparam int ADDR_W     = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

	// fixed field widths
	localparam int VALUE_W    = 13;
	localparam int CFG_W      = 13;
	localparam int WORD_W     = 31;
	localparam int BITCNT_W   = $clog2(WORD_W);
	localparam int CFG_IDX_W  = 2;

	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [VALUE_W-1:0]   value_t;
	typedef logic [CFG_W-1:0]     cfg_t;
	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [BITCNT_W-1:0]  bitcnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_RANGE_MAX    = cfg_idx_t'(0);
	localparam cfg_idx_t REG_SAMPLE_COUNT = cfg_idx_t'(1);

	// request actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DRAW  = 1'b1;

	// kind of result to load into the output register
	typedef enum logic [1:0] {
		OUT_START,
		OUT_EXH,
		OUT_DRAW
	} out_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      latch;
		logic      fill_init;
		logic      fill_step;
		logic      div_init;
		logic      div_step;
		logic      rd_tail;
		logic      cap_val;
		logic      swap_wr;
		logic      out_load;
		out_kind_t out_kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_start;
		logic exhausted;
		logic fill_done;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/ursd_if.sv =====
`default_nettype none

// request channel
interface ursd_in_if;
	logic                  valid;
	logic                  ready;
	logic                  action;
	ursd_pkg::word_t       random_word;

	modport source (output valid, output action, output random_word, input ready);
	modport sink   (input valid, input action, input random_word, output ready);
endinterface

// result channel
interface ursd_out_if;
	logic                  valid;
	logic                  ready;
	ursd_pkg::value_t      value;
	logic                  status;
	logic                  last_of_sample;

	modport source (output valid, output value, output status, output last_of_sample,
		input ready);
	modport sink   (input valid, input value, input status, input last_of_sample,
		output ready);
endinterface

// register write channel
interface ursd_cfg_if;
	logic                  valid;
	logic                  ready;
	ursd_pkg::cfg_idx_t    index;
	ursd_pkg::cfg_t        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ursd_dp.sv =====
`default_nettype none

module ursd_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ursd_pkg::cmd_t     cmd,
	output ursd_pkg::stat_t         stat,
	// register writes
	input  wire logic               cfg_valid,
	input  wire ursd_pkg::cfg_idx_t cfg_index,
	input  wire ursd_pkg::cfg_t     cfg_data,
	// request payload
	input  wire logic               in_action,
	input  wire ursd_pkg::word_t    in_random_word,
	// result side
	input  wire logic               out_ready,
	output logic                    out_valid,
	output ursd_pkg::value_t        out_value,
	output logic                    out_status,
	output logic                    out_last_of_sample
);

	ursd_pkg::cfg_t    range_max_q;
	ursd_pkg::cfg_t    sample_count_q;
	ursd_pkg::cnt_t    remaining_q;
	ursd_pkg::cfg_t    drawn_q;
	logic              action_q;
	ursd_pkg::word_t   word_q;
	ursd_pkg::cnt_t    rem_q;
	ursd_pkg::bitcnt_t bit_cnt_q;
	ursd_pkg::cnt_t    fill_cnt_q;
	ursd_pkg::value_t  rdata_q;
	ursd_pkg::value_t  draw_value_q;
	logic              out_valid_q;
	ursd_pkg::value_t  out_value_q;
	logic              out_status_q;
	logic              out_last_q;

	ursd_pkg::value_t  pool_mem [ursd_pkg::POOL_DEPTH];

	ursd_pkg::cnt_t    fill_n;
	logic [ursd_pkg::CNT_W:0] trial;
	ursd_pkg::cnt_t    rem_d;
	ursd_pkg::addr_t   idx_addr;
	ursd_pkg::addr_t   tail_addr;
	ursd_pkg::addr_t   raddr;
	logic              exhausted;

	// pool size for a start, saturated to the memory depth
	always_comb begin
		if (int'(range_max_q) > ursd_pkg::POOL_DEPTH) begin
			fill_n = ursd_pkg::cnt_t'(ursd_pkg::POOL_DEPTH);
		end else begin
			fill_n = ursd_pkg::cnt_t'(range_max_q);
		end
	end

	// one restoring step of word mod remaining
	always_comb begin
		trial = {rem_q, word_q[ursd_pkg::WORD_W-1]};
		if (trial >= {1'b0, remaining_q}) begin
			rem_d = ursd_pkg::cnt_t'(trial - {1'b0, remaining_q});
		end else begin
			rem_d = ursd_pkg::cnt_t'(trial);
		end
	end

	assign idx_addr  = rem_q[ursd_pkg::ADDR_W-1:0];
	assign tail_addr = ursd_pkg::addr_t'(remaining_q - ursd_pkg::cnt_t'(1));
	assign raddr     = cmd.rd_tail ? tail_addr : idx_addr;
	assign exhausted = (drawn_q >= sample_count_q) || (remaining_q == '0);

	// status to the controller
	always_comb begin
		stat.is_start  = (action_q == ursd_pkg::ACT_START);
		stat.exhausted = exhausted;
		stat.fill_done = (fill_cnt_q == remaining_q);
		stat.div_last  = (bit_cnt_q == '0);
		stat.out_free  = !out_valid_q || out_ready;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_max_q    <= ursd_pkg::cfg_t'(4096);
			sample_count_q <= ursd_pkg::cfg_t'(4096);
		end else if (cfg_valid) begin
			case (cfg_index)
				ursd_pkg::REG_RANGE_MAX:    range_max_q    <= cfg_data;
				ursd_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shuffle state: remaining and drawn counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			drawn_q     <= '0;
		end else if (cmd.fill_init) begin
			remaining_q <= fill_n;
			drawn_q     <= '0;
		end else if (cmd.swap_wr) begin
			remaining_q <= remaining_q - ursd_pkg::cnt_t'(1);
			drawn_q     <= drawn_q + ursd_pkg::cfg_t'(1);
		end
	end

	// request capture, fill counter and serial modulo
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= in_action;
			word_q   <= in_random_word;
		end else if (cmd.div_step) begin
			word_q   <= {word_q[ursd_pkg::WORD_W-2:0], 1'b0};
		end
		if (cmd.fill_init) begin
			fill_cnt_q <= '0;
		end else if (cmd.fill_step) begin
			fill_cnt_q <= fill_cnt_q + ursd_pkg::cnt_t'(1);
		end
		if (cmd.div_init) begin
			rem_q     <= '0;
			bit_cnt_q <= ursd_pkg::bitcnt_t'(ursd_pkg::WORD_W - 1);
		end else if (cmd.div_step) begin
			rem_q     <= rem_d;
			bit_cnt_q <= bit_cnt_q - ursd_pkg::bitcnt_t'(1);
		end
		if (cmd.cap_val) begin
			draw_value_q <= rdata_q;
		end
	end

	// pool memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.fill_step) begin
			pool_mem[fill_cnt_q[ursd_pkg::ADDR_W-1:0]] <=
				ursd_pkg::value_t'(fill_cnt_q + ursd_pkg::cnt_t'(1));
		end else if (cmd.swap_wr) begin
			pool_mem[idx_addr] <= rdata_q;
		end
		rdata_q <= pool_mem[raddr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				ursd_pkg::OUT_DRAW: begin
					out_value_q  <= draw_value_q;
					out_status_q <= 1'b0;
					out_last_q   <= (drawn_q == sample_count_q);
				end
				ursd_pkg::OUT_EXH: begin
					out_value_q  <= '0;
					out_status_q <= 1'b1;
					out_last_q   <= 1'b0;
				end
				default: begin
					out_value_q  <= '0;
					out_status_q <= 1'b0;
					out_last_q   <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign out_value          = out_value_q;
	assign out_status         = out_status_q;
	assign out_last_of_sample = out_last_q;

	// the draw index lands inside the live part of the pool
	a_idx_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_val |-> (rem_q < remaining_q))
		else $error("draw index outside live pool");

	// fill writes stay below the loaded pool size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> (fill_cnt_q < remaining_q))
		else $error("fill beyond pool size");

	// a swap only happens on a non-exhausted pool
	a_swap_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap_wr |-> !exhausted)
		else $error("swap on exhausted pool");

	// a result is loaded only when the output register is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten");

endmodule

`default_nettype wire

// ===== rtl/ursd_ctrl.sv =====
`default_nettype none

module ursd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ursd_pkg::stat_t stat,
	output ursd_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FILL,
		S_DIV,
		S_RDA,
		S_RDB,
		S_WR,
		S_DONE
	} state_t;

	state_t              state_q;
	ursd_pkg::out_kind_t kind_q;

	assign in_ready = (state_q == S_IDLE);

	// commands decoded from state
	always_comb begin
		cmd           = '0;
		cmd.out_kind  = kind_q;
		case (state_q)
			S_IDLE:   cmd.latch     = in_valid;
			S_DECODE: begin
				cmd.fill_init = stat.is_start;
				cmd.div_init  = !stat.is_start && !stat.exhausted;
			end
			S_FILL:   cmd.fill_step = !stat.fill_done;
			S_DIV:    cmd.div_step  = 1'b1;
			S_RDA:    ;
			S_RDB: begin
				cmd.rd_tail = 1'b1;
				cmd.cap_val = 1'b1;
			end
			S_WR:     cmd.swap_wr   = 1'b1;
			S_DONE:   cmd.out_load  = stat.out_free;
			default:  ;
		endcase
	end

	// state and result kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= ursd_pkg::OUT_START;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (stat.is_start) begin
						kind_q  <= ursd_pkg::OUT_START;
						state_q <= S_FILL;
					end else if (stat.exhausted) begin
						kind_q  <= ursd_pkg::OUT_EXH;
						state_q <= S_DONE;
					end else begin
						kind_q  <= ursd_pkg::OUT_DRAW;
						state_q <= S_DIV;
					end
				end
				S_FILL: begin
					if (stat.fill_done) begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_RDA;
					end
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_WR;
				S_WR:   state_q <= S_DONE;
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a draw always passes through the full modulo before the pool is touched
	a_div_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && stat.div_last) |=> (state_q == S_RDA))
		else $error("modulo did not hand over to pool read");

	// an accepted request is decoded on the next cycle
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_DECODE && !in_ready))
		else $error("accepted request not decoded");

endmodule

`default_nettype wire

// ===== rtl/unique_random_sample_draw.sv =====
// channel   dir  handshake      payload
// cfg_ch    in   valid/ready    index (2b), data (13b)
// in_ch     in   valid/ready    action (1b), random_word (31b)
// out_ch    out  valid/ready    value (13b), status (1b), last_of_sample (1b)
//
// one request at a time; ready is high only while the controller is idle
// draw: the result follows the 31-step serial modulo
// and the pool memory states (read index, read tail, write back)
// start: fills range_max entries (saturated to pool depth), one pool write per cycle
// exhausted draw: decode, then the result load; a held result stalls only the final load
// config writes are always taken; arst_n clears counts and control, not the pool
`default_nettype none

module unique_random_sample_draw (
	input  wire logic clk,
	input  wire logic arst_n,
	ursd_cfg_if.sink  cfg_ch,
	ursd_in_if.sink   in_ch,
	ursd_out_if.source out_ch
);

	ursd_pkg::cmd_t  cmd;
	ursd_pkg::stat_t stat;
	logic            in_ready;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = in_ready;

	// sequencer
	ursd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// pool, counters, modulo unit and output register
	ursd_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.cfg_valid          (cfg_ch.valid),
		.cfg_index          (cfg_ch.index),
		.cfg_data           (cfg_ch.data),
		.in_action          (in_ch.action),
		.in_random_word     (in_ch.random_word),
		.out_ready          (out_ch.ready),
		.out_valid          (out_ch.valid),
		.out_value          (out_ch.value),
		.out_status         (out_ch.status),
		.out_last_of_sample (out_ch.last_of_sample)
	);

endmodule

`default_nettype wire

// ===== verif/tb_unique_random_sample_draw.sv =====
module tb_unique_random_sample_draw;

	localparam int unsigned      CYCLE_LIMIT  = 10_000_000;
	localparam int unsigned      DRAIN_CYCLES = 60;
	localparam int unsigned      RANDOM_ITEMS = 450;
	localparam ursd_pkg::cfg_t   CFG_MAX      = '1;
	localparam ursd_pkg::word_t  WORD_MAX     = '1;

	// register indexes that decode to nothing
	localparam ursd_pkg::cfg_idx_t REG_UNUSED_2 = ursd_pkg::cfg_idx_t'(2);
	localparam ursd_pkg::cfg_idx_t REG_UNUSED_3 = ursd_pkg::cfg_idx_t'(3);

	typedef struct packed {
		ursd_pkg::value_t value;
		logic             status;
		logic             last_of_sample;
	} draw_result_t;

	logic clk;
	logic arst_n;

	ursd_cfg_if cfg_ch ();
	ursd_in_if  in_ch ();
	ursd_out_if out_ch ();

	unique_random_sample_draw i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// shadow of the shuffle state and registers
	ursd_pkg::value_t pool_copy [ursd_pkg::POOL_DEPTH];
	ursd_pkg::cnt_t   left_in_pool;
	ursd_pkg::cnt_t   drawn_so_far;
	ursd_pkg::cfg_t   cfg_range_max;
	ursd_pkg::cfg_t   cfg_sample_count;

	draw_result_t pending_results [$];

	logic        idle_on;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned n_requests;
	int unsigned n_results;
	int unsigned n_starts;
	int unsigned n_values;
	int unsigned n_exhausted;
	int unsigned n_hold_offs;

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// expected result of one request, advances the shadow state
	function automatic draw_result_t predict_draw(input logic act, input ursd_pkg::word_t word);
		draw_result_t res;
		int unsigned  fill;
		int unsigned  slot;
		int unsigned  tail;
		res = '0;
		if (act == ursd_pkg::ACT_START) begin
			fill = (cfg_range_max > ursd_pkg::POOL_DEPTH) ? ursd_pkg::POOL_DEPTH : cfg_range_max;
			for (int unsigned i = 0; i < fill; i++)
				pool_copy[i] = ursd_pkg::value_t'(i + 1);
			left_in_pool = ursd_pkg::cnt_t'(fill);
			drawn_so_far = '0;
			n_starts++;
		end else if (drawn_so_far >= cfg_sample_count || left_in_pool == '0) begin
			// sample done or pool empty
			res.status = 1'b1;
			n_exhausted++;
		end else begin
			slot = int'(word) % int'(left_in_pool);
			tail = int'(left_in_pool) - 1;
			res.value = pool_copy[slot];
			pool_copy[slot] = pool_copy[tail];
			left_in_pool = ursd_pkg::cnt_t'(tail);
			drawn_so_far = drawn_so_far + 1'b1;
			res.last_of_sample = (drawn_so_far == cfg_sample_count);
			n_values++;
		end
		return res;
	endfunction

	// one request on the input channel, with an optional gap first
	task automatic send_request(input logic act, input ursd_pkg::word_t word);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.action      <= act;
		in_ch.random_word <= word;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(predict_draw(act, word));
		n_requests++;
	endtask

	// drop valid and wait until every result has come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input ursd_pkg::cfg_idx_t idx, input ursd_pkg::cfg_t data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == ursd_pkg::REG_RANGE_MAX)
			cfg_range_max = data;
		else if (idx == ursd_pkg::REG_SAMPLE_COUNT)
			cfg_sample_count = data;
	endtask

	task automatic cfg_done();
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_config(input int unsigned range, input int unsigned count);
		write_reg(ursd_pkg::REG_RANGE_MAX, ursd_pkg::cfg_t'(range));
		write_reg(ursd_pkg::REG_SAMPLE_COUNT, ursd_pkg::cfg_t'(count));
		cfg_done();
	endtask

	function automatic ursd_pkg::word_t rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return WORD_MAX;
			2: return ursd_pkg::word_t'($urandom_range(0, 15));
			default: return ursd_pkg::word_t'($urandom);
		endcase
	endfunction

	task automatic check_result();
		draw_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result with no request pending: value %0d status %0b",
				out_ch.value, out_ch.status));
			return;
		end
		want = pending_results.pop_front();
		n_results++;
		if (out_ch.value !== want.value)
			report_mismatch($sformatf("value %0d, expected %0d", out_ch.value, want.value));
		if (out_ch.status !== want.status)
			report_mismatch($sformatf("status %0b, expected %0b", out_ch.status, want.status));
		if (out_ch.last_of_sample !== want.last_of_sample)
			report_mismatch($sformatf("last_of_sample %0b, expected %0b",
				out_ch.last_of_sample, want.last_of_sample));
	endtask

	// result channel: checking
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			check_result();
	end

	// result channel: ready pattern and long hold-off count
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// draws with no start yet see an empty pool
	task automatic test_draw_before_start();
		send_request(ursd_pkg::ACT_DRAW, '0);
		send_request(ursd_pkg::ACT_DRAW, WORD_MAX);
		settle();
	endtask

	// reset registers give a full 4096 pool
	task automatic test_default_pool();
		send_request(ursd_pkg::ACT_START, WORD_MAX);
		send_request(ursd_pkg::ACT_DRAW, WORD_MAX);
		send_request(ursd_pkg::ACT_DRAW, '0);
		settle();
	endtask

	// one value pool, then sample done
	task automatic test_single_value();
		set_config(1, 1);
		send_request(ursd_pkg::ACT_START, '0);
		send_request(ursd_pkg::ACT_DRAW, WORD_MAX);
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		settle();
	endtask

	// range below sample count, pool drains first
	task automatic test_pool_runs_dry();
		set_config(4, 8);
		send_request(ursd_pkg::ACT_START, rand_word());
		send_request(ursd_pkg::ACT_DRAW, WORD_MAX);
		send_request(ursd_pkg::ACT_DRAW, '0);
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		send_request(ursd_pkg::ACT_DRAW, WORD_MAX);
		settle();
	endtask

	// zero range leaves the pool empty
	task automatic test_empty_range();
		set_config(0, 5);
		send_request(ursd_pkg::ACT_START, rand_word());
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		settle();
	endtask

	// range beyond the pool depth saturates
	task automatic test_range_saturation();
		set_config(CFG_MAX, 2);
		send_request(ursd_pkg::ACT_START, rand_word());
		send_request(ursd_pkg::ACT_DRAW, '0);
		send_request(ursd_pkg::ACT_DRAW, WORD_MAX);
		settle();
	endtask

	// zero sample count, writes to unused indexes change nothing
	task automatic test_zero_sample_and_unused_regs();
		write_reg(ursd_pkg::REG_SAMPLE_COUNT, '0);
		write_reg(ursd_pkg::REG_RANGE_MAX, ursd_pkg::cfg_t'(4));
		write_reg(REG_UNUSED_2, CFG_MAX);
		write_reg(REG_UNUSED_3, ursd_pkg::cfg_t'(7));
		cfg_done();
		send_request(ursd_pkg::ACT_START, rand_word());
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		settle();
	endtask

	// register changes between requests act on the running sample
	task automatic test_live_register_change();
		set_config(6, 6);
		send_request(ursd_pkg::ACT_START, rand_word());
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		settle();
		write_reg(ursd_pkg::REG_SAMPLE_COUNT, ursd_pkg::cfg_t'(1));
		cfg_done();
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		settle();
		set_config(3, 5);
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		send_request(ursd_pkg::ACT_START, rand_word());
		send_request(ursd_pkg::ACT_DRAW, rand_word());
		settle();
	endtask

	// receiver holds off while requests keep coming
	task automatic test_output_backpressure();
		set_config(30, 30);
		idle_on = 1'b0;
		hold_left = 300;
		n_hold_offs++;
		send_request(ursd_pkg::ACT_START, rand_word());
		repeat (6) send_request(ursd_pkg::ACT_DRAW, rand_word());
		settle();
		idle_on = 1'b1;
	endtask

	function automatic int unsigned pick_range();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return ursd_pkg::POOL_DEPTH;
			2: return CFG_MAX;
			3: return $urandom_range(ursd_pkg::POOL_DEPTH + 1, CFG_MAX);
			4, 5: return $urandom_range(41, 400);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic int unsigned pick_sample(input int unsigned range);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return CFG_MAX;
			2: return $urandom_range(0, CFG_MAX);
			3: return $urandom_range(0, range);
			default: return $urandom_range(1, range + 2);
		endcase
	endfunction

	// random samples: a start, then draws, now and then a restart
	task automatic test_random_samples(input int unsigned target);
		int unsigned issued;
		int unsigned range;
		int unsigned count;
		int unsigned draws;
		issued = 0;
		while (issued < target) begin
			idle_on = (issued + 70 > target) ? 1'b0 : ($urandom_range(0, 4) != 0);
			range = pick_range();
			count = pick_sample(range);
			settle();
			set_config(range, count);
			send_request(ursd_pkg::ACT_START, rand_word());
			issued++;
			draws = (count < range) ? count : range;
			draws = $urandom_range(1, (draws > 37) ? 40 : draws + 3);
			repeat (draws) begin
				if ($urandom_range(0, 24) == 0)
					send_request(ursd_pkg::ACT_START, rand_word());
				else
					send_request(ursd_pkg::ACT_DRAW, rand_word());
				issued++;
			end
		end
		settle();
	endtask

	// sequence
	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.action      = ursd_pkg::ACT_START;
		in_ch.random_word = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = ursd_pkg::REG_RANGE_MAX;
		cfg_ch.data       = '0;
		out_ch.ready      = 1'b0;
		idle_on           = 1'b1;
		hold_left         = 0;
		stall_left        = 0;
		cycle_count       = 0;
		mismatches        = 0;
		n_requests        = 0;
		n_results         = 0;
		n_starts          = 0;
		n_values          = 0;
		n_exhausted       = 0;
		n_hold_offs       = 0;
		left_in_pool      = '0;
		drawn_so_far      = '0;
		cfg_range_max     = ursd_pkg::cfg_t'(ursd_pkg::POOL_DEPTH);
		cfg_sample_count  = ursd_pkg::cfg_t'(ursd_pkg::POOL_DEPTH);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_draw_before_start();
		test_default_pool();
		test_single_value();
		test_pool_runs_dry();
		test_empty_range();
		test_range_saturation();
		test_zero_sample_and_unused_regs();
		test_live_register_change();
		test_output_backpressure();
		test_random_samples(RANDOM_ITEMS);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("%0d requests: %0d starts, %0d values drawn, %0d exhausted draws",
			n_requests, n_starts, n_values, n_exhausted);
		$display("%0d results checked, %0d long output hold-offs, %0d mismatches",
			n_results, n_hold_offs, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
